>>> hdl/bac_pkg.sv
// ============================================================================
// bac_pkg
// Shared types and constants of the contiguous/chained block allocator:
// operation and status codes, controller states and the command/status
// bundles exchanged between controller and datapath.
// ============================================================================
package bac_pkg;

    // Pool size default and fixed field widths
    localparam int NUM_BLOCKS_DEF = 128;
    localparam int KIND_W         = 2;
    localparam int CNT_W          = 8;
    localparam int BLK_W          = 7;
    localparam int STAT_W         = 2;
    localparam int LINK_W         = 8;

    // End-of-chain marker and active_blocks reset value
    localparam logic [LINK_W-1:0] LINK_END   = 8'hFF;
    localparam logic [CNT_W-1:0]  ACT_RESET  = 8'd128;

    // Operation kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC_CONTIG = 2'd0,
        KIND_ALLOC_CHAIN  = 2'd1,
        KIND_FREE_RANGE   = 2'd2,
        KIND_FREE_CHAIN   = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_START = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FIT,
        S_MARK,
        S_COUNT,
        S_LINK,
        S_FREE,
        S_WALK_RD,
        S_WALK_WR,
        S_RESULT
    } t_ctl_state;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_SCAN_INIT,
        DP_FIT,
        DP_COUNT,
        DP_LINK,
        DP_MARK_INIT,
        DP_MARK,
        DP_TERM,
        DP_FREE_INIT,
        DP_FREE,
        DP_WALK_INIT,
        DP_WALK_RD,
        DP_WALK_WR,
        DP_RESULT
    } t_dp_op;

    // Controller to datapath
    typedef struct packed {
        t_dp_op  op;
        t_status res;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  cnt_zero;
        logic  start_out;
        logic  clr_last;
        logic  hit;
        logic  scan_end;
        logic  enough;
        logic  mark_last;
        logic  free_done;
        logic  walk_done;
        logic  out_free;
    } t_dp_sts;

endpackage

>>> hdl/bac_dpath.sv
// ============================================================================
// bac_dpath
// Allocator datapath: occupancy and link memories, scan/walk counters,
// configuration register and the output register.
// ============================================================================
module bac_dpath
    import bac_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [CNT_W-1:0]  i_block_count,
    input  logic [BLK_W-1:0]  i_start_block,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [BLK_W-1:0]  o_first_block,
    output logic [CNT_W-1:0]  o_blocks_changed
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Memories
    logic              occ_mem  [NUM_BLOCKS];
    logic [LINK_W-1:0] link_mem [NUM_BLOCKS];

    // Control registers
    logic [CNT_W-1:0] r_act;
    logic [AW-1:0]    r_clr;
    logic             r_out_valid;

    // Item and working registers
    t_kind            r_kind;
    logic [CNT_W-1:0] r_cnt;
    logic [BLK_W-1:0] r_start;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_ridx;
    logic             r_vld;
    logic [CNT_W-1:0] r_run;
    logic [CNT_W-1:0] r_begin;
    logic             r_hit;
    logic [CNT_W-1:0] r_nfree;
    logic [CNT_W-1:0] r_taken;
    logic [CNT_W-1:0] r_prev;
    logic [CNT_W-1:0] r_stop;
    logic [CNT_W-1:0] r_cur;
    logic [CNT_W-1:0] r_steps;
    logic [CNT_W-1:0] r_first_blk;
    logic [CNT_W-1:0] r_changed;
    logic             r_occ_q;
    logic [LINK_W-1:0] r_link_q;

    // Output register
    t_status          r_o_status;
    logic [BLK_W-1:0] r_o_first;
    logic [CNT_W-1:0] r_o_changed;

    // Combinational
    logic [CNT_W-1:0] pool;
    logic             issue;
    logic             is_scan;
    logic             blk_free;
    logic [CNT_W:0]   run_end;
    logic [CNT_W:0]   range_sum;
    logic [CNT_W-1:0] range_stop;
    logic [AW-1:0]    rd_addr;
    logic             occ_we;
    logic [AW-1:0]    occ_wa;
    logic             occ_wd;
    logic             link_we;
    logic [AW-1:0]    link_wa;
    logic [LINK_W-1:0] link_wd;

    // Pool size saturates at the memory depth
    assign pool = (int'(r_act) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : r_act;

    assign is_scan  = (i_cmd.op == DP_FIT) || (i_cmd.op == DP_COUNT)
                   || (i_cmd.op == DP_LINK);
    assign issue    = r_idx < r_n;
    assign blk_free = r_vld && !r_occ_q;
    assign run_end  = {1'b0, r_begin} + {1'b0, r_cnt} - {{CNT_W{1'b0}}, 1'b1};
    assign range_sum  = {2'b00, r_start} + {1'b0, r_cnt};
    assign range_stop = (range_sum > {1'b0, r_n}) ? r_n : range_sum[CNT_W-1:0];
    assign rd_addr  = (i_cmd.op == DP_WALK_RD) ? AW'(r_cur) : AW'(r_idx);

    // Status to controller
    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.start_out = ({1'b0, r_start} >= r_n);
        o_sts.clr_last  = (r_clr == AW'(NUM_BLOCKS - 1));
        o_sts.hit       = r_hit;
        o_sts.scan_end  = !r_vld && !issue;
        o_sts.enough    = (r_nfree >= r_cnt);
        o_sts.mark_last = ({1'b0, r_idx} == run_end);
        o_sts.free_done = (r_idx >= r_stop);
        o_sts.walk_done = (r_cur == LINK_END) || (r_cur >= r_n) || (r_steps >= r_n);
        o_sts.out_free  = !r_out_valid || !i_stall;
    end

    // Memory write decode
    always_comb begin
        occ_we  = 1'b0;
        occ_wa  = AW'(r_idx);
        occ_wd  = 1'b0;
        link_we = 1'b0;
        link_wa = AW'(r_prev);
        link_wd = LINK_END;
        unique case (i_cmd.op)
            DP_CLEAR: begin
                occ_we  = 1'b1;
                occ_wa  = r_clr;
                link_we = 1'b1;
                link_wa = r_clr;
            end
            DP_MARK: begin
                occ_we = 1'b1;
                occ_wd = 1'b1;
            end
            DP_LINK: begin
                // claim the free block, link the previous one to it
                occ_we  = blk_free;
                occ_wa  = AW'(r_ridx);
                occ_wd  = 1'b1;
                link_we = blk_free && (r_taken != '0);
                link_wd = r_ridx;
            end
            DP_TERM: begin
                link_we = 1'b1;
            end
            DP_FREE: begin
                occ_we = (r_idx < r_stop);
            end
            DP_WALK_WR: begin
                occ_we  = 1'b1;
                occ_wa  = AW'(r_cur);
                link_we = 1'b1;
                link_wa = AW'(r_cur);
            end
            default: begin
            end
        endcase
    end

    // Memories with registered read
    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            occ_mem[occ_wa] <= occ_wd;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        r_occ_q  <= occ_mem[rd_addr];
        r_link_q <= link_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= ACT_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_act <= i_cfg_wr_data;
            end
            if (i_cmd.op == DP_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.op == DP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        // streaming scan: issue read at r_idx, evaluate block r_ridx
        if (is_scan) begin
            r_vld  <= issue;
            r_ridx <= r_idx;
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end else begin
            r_vld <= 1'b0;
        end

        unique case (i_cmd.op)
            DP_LOAD: begin
                r_kind      <= t_kind'(i_kind);
                r_cnt       <= i_block_count;
                r_start     <= i_start_block;
                r_n         <= pool;
                r_first_blk <= '0;
                r_changed   <= '0;
            end
            DP_SCAN_INIT: begin
                r_idx   <= '0;
                r_run   <= '0;
                r_hit   <= 1'b0;
                r_nfree <= '0;
                r_taken <= '0;
            end
            DP_FIT: begin
                // first-fit run tracking
                if (r_vld) begin
                    if (!r_occ_q) begin
                        if (r_run == '0) begin
                            r_begin <= r_ridx;
                        end
                        r_run <= r_run + CNT_W'(1);
                        if (r_run + CNT_W'(1) == r_cnt) begin
                            r_hit <= 1'b1;
                        end
                    end else begin
                        r_run <= '0;
                    end
                end
            end
            DP_COUNT: begin
                if (blk_free) begin
                    r_nfree <= r_nfree + CNT_W'(1);
                end
            end
            DP_LINK: begin
                if (blk_free) begin
                    if (r_taken == '0) begin
                        r_first_blk <= r_ridx;
                    end
                    r_prev  <= r_ridx;
                    r_taken <= r_taken + CNT_W'(1);
                    if (r_taken + CNT_W'(1) == r_cnt) begin
                        r_hit <= 1'b1;
                    end
                end
            end
            DP_MARK_INIT: begin
                r_idx       <= r_begin;
                r_first_blk <= r_begin;
                r_changed   <= r_cnt;
            end
            DP_MARK: begin
                r_idx <= r_idx + CNT_W'(1);
            end
            DP_TERM: begin
                r_changed <= r_cnt;
            end
            DP_FREE_INIT: begin
                r_idx     <= {1'b0, r_start};
                r_stop    <= range_stop;
                r_changed <= range_stop - {1'b0, r_start};
            end
            DP_FREE: begin
                if (r_idx < r_stop) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            DP_WALK_INIT: begin
                r_cur   <= {1'b0, r_start};
                r_steps <= '0;
            end
            DP_WALK_WR: begin
                if (r_occ_q) begin
                    r_changed <= r_changed + CNT_W'(1);
                end
                r_cur   <= r_link_q;
                r_steps <= r_steps + CNT_W'(1);
            end
            DP_RESULT: begin
                r_o_status <= i_cmd.res;
                if (i_cmd.res == ST_DONE) begin
                    r_o_first   <= r_first_blk[BLK_W-1:0];
                    r_o_changed <= r_changed;
                end else begin
                    r_o_first   <= '0;
                    r_o_changed <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_o_status;
    assign o_first_block    = r_o_first;
    assign o_blocks_changed = r_o_changed;

    // Marking stays inside the found run, which lies inside the pool
    a_mark_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_MARK) |->
            (({1'b0, r_idx} <= run_end) && (run_end < {1'b0, r_n})))
        else $error("mark outside found run");

    // Linking never claims more blocks than requested
    a_link_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_LINK) |-> (r_taken < r_cnt))
        else $error("chain longer than request");

    // Range free stays inside the active pool
    a_free_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_FREE && occ_we) |-> (r_idx < r_n))
        else $error("range free past pool end");

    // A failed operation reports no block and no change
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_RESULT && i_cmd.res != ST_DONE) |=>
            (o_first_block == '0 && o_blocks_changed == '0))
        else $error("failure result carries data");

endmodule

>>> hdl/bac_ctrl.sv
// ============================================================================
// bac_ctrl
// Allocator controller: sequences the clearing pass, operation decode,
// scans, marking, linking, freeing walks and result hand-off.
// ============================================================================
module bac_ctrl
    import bac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_ctl_state r_state, n_state;
    t_status    r_res, n_res;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_res   <= ST_DONE;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        o_cmd.op  = DP_NOP;
        o_cmd.res = r_res;
        o_stall   = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.kind) inside
                    KIND_ALLOC_CONTIG, KIND_ALLOC_CHAIN: begin
                        if (i_sts.cnt_zero) begin
                            n_res   = ST_DONE;
                            n_state = S_RESULT;
                        end else begin
                            o_cmd.op = DP_SCAN_INIT;
                            n_state  = (i_sts.kind == KIND_ALLOC_CONTIG) ? S_FIT : S_COUNT;
                        end
                    end
                    KIND_FREE_RANGE: begin
                        if (i_sts.start_out) begin
                            n_res   = ST_BAD_START;
                            n_state = S_RESULT;
                        end else begin
                            o_cmd.op = DP_FREE_INIT;
                            n_state  = S_FREE;
                        end
                    end
                    default: begin
                        if (i_sts.start_out) begin
                            n_res   = ST_BAD_START;
                            n_state = S_RESULT;
                        end else begin
                            o_cmd.op = DP_WALK_INIT;
                            n_state  = S_WALK_RD;
                        end
                    end
                endcase
            end
            S_FIT: begin
                if (i_sts.hit) begin
                    o_cmd.op = DP_MARK_INIT;
                    n_state  = S_MARK;
                end else if (i_sts.scan_end) begin
                    n_res   = ST_NO_SPACE;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.op = DP_FIT;
                end
            end
            S_MARK: begin
                o_cmd.op = DP_MARK;
                if (i_sts.mark_last) begin
                    n_res   = ST_DONE;
                    n_state = S_RESULT;
                end
            end
            S_COUNT: begin
                if (i_sts.scan_end) begin
                    if (i_sts.enough) begin
                        o_cmd.op = DP_SCAN_INIT;
                        n_state  = S_LINK;
                    end else begin
                        n_res   = ST_NO_SPACE;
                        n_state = S_RESULT;
                    end
                end else begin
                    o_cmd.op = DP_COUNT;
                end
            end
            S_LINK: begin
                if (i_sts.hit) begin
                    o_cmd.op = DP_TERM;
                    n_res    = ST_DONE;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.op = DP_LINK;
                end
            end
            S_FREE: begin
                if (i_sts.free_done) begin
                    n_res   = ST_DONE;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.op = DP_FREE;
                end
            end
            S_WALK_RD: begin
                if (i_sts.walk_done) begin
                    n_res   = ST_DONE;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.op = DP_WALK_RD;
                    n_state  = S_WALK_WR;
                end
            end
            S_WALK_WR: begin
                o_cmd.op = DP_WALK_WR;
                n_state  = S_WALK_RD;
            end
            S_RESULT: begin
                // wait for the output register to drain
                if (i_sts.out_free) begin
                    o_cmd.op = DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result hand-off always returns to idle
    a_result_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("result not followed by idle");

    // Every walk update follows its memory read
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_WR) |-> ($past(r_state) == S_WALK_RD))
        else $error("walk update without read");

    // Datapath never starts a new result while the old one is stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_RESULT) |-> i_sts.out_free)
        else $error("result overwrite");

endmodule

>>> hdl/block_allocator_contig_chain_top.sv
// ============================================================================
// block_allocator_contig_chain_top
// First-fit contiguous and linked block allocator over a pool of blocks,
// with an occupancy memory and a next-block link memory.
// ============================================================================
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ---------------------------------
//  cfg      in         i_cfg_wr_en               i_cfg_wr_data (active_blocks)
//  request  in         i_valid / o_stall         i_kind, i_block_count, i_start_block
//  result   out        o_valid / i_stall         o_status, o_first_block,
//                                                o_blocks_changed
//
//  One operation at a time; a scan reads one block per cycle from the
//  occupancy memory. Contiguous allocate: a first-fit pass, then marking
//  of the run. Chained allocate: a count pass, then a link pass. Range
//  free: one pass over the range. Chain free: a read and an update per block.
//  After reset a clearing pass over all NUM_BLOCKS entries holds o_stall high.
//  A new request is taken while the previous result waits in the output
//  register; i_stall only delays hand-off of the next result.
//
module block_allocator_contig_chain_top
    import bac_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [CNT_W-1:0]  i_block_count,
    input  logic [BLK_W-1:0]  i_start_block,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [BLK_W-1:0]  o_first_block,
    output logic [CNT_W-1:0]  o_blocks_changed
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller
    bac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Datapath
    bac_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_kind           (i_kind),
        .i_block_count    (i_block_count),
        .i_start_block    (i_start_block),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_first_block    (o_first_block),
        .o_blocks_changed (o_blocks_changed)
    );

endmodule

>>> dv/tb_block_allocator_contig_chain_top.sv
// ----------------------------------------------------------------------------
// Block allocator testbench
// Drives allocate and free requests into block_allocator_contig_chain_top,
// keeps its own occupancy bitmap and link table to predict each status,
// first block and block count, and checks every result transfer in order.
// Covers pool-size extremes, allocation failures, clipped range frees,
// chain walks that leave the pool, and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_block_allocator_contig_chain_top;
    import bac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  first_block;
        logic [CNT_W-1:0]  changed;
    } t_alloc_result;

    // One allocation still believed to be held, used to build well-formed frees
    typedef struct {
        logic chained;
        int   first;
        int   count;
    } t_alloc_rec;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CNT_W-1:0]  i_cfg_wr_data;
    logic              i_valid;
    logic              o_stall;
    logic [KIND_W-1:0] i_kind;
    logic [CNT_W-1:0]  i_block_count;
    logic [BLK_W-1:0]  i_start_block;
    logic              o_valid;
    logic              i_stall;
    logic [STAT_W-1:0] o_status;
    logic [BLK_W-1:0]  o_first_block;
    logic [CNT_W-1:0]  o_blocks_changed;

    // Shadow of the allocator state
    logic              occ_map  [NUM_BLOCKS_DEF];
    logic [LINK_W-1:0] link_tbl [NUM_BLOCKS_DEF];
    logic [CNT_W-1:0]  pool_cfg;

    t_alloc_result pending_results[$];
    t_alloc_rec    live_allocs[$];
    int            error_count = 0;
    int            hold_cnt    = 0;
    int            idle_cycles = 0;

    block_allocator_contig_chain_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_block_count    (i_block_count),
        .i_start_block    (i_start_block),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_first_block    (o_first_block),
        .o_blocks_changed (o_blocks_changed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Effective pool size: register value saturated at the pool depth
    function automatic int pool_blocks();
        return (int'(pool_cfg) > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(pool_cfg);
    endfunction

    // Apply one operation to the shadow state and return what the block should report
    function automatic t_alloc_result compute_alloc_result(t_kind kind, int cnt, int start);
        t_alloc_result res;
        int n;
        int run;
        int begin_blk;
        int nfree;
        int taken;
        int prev;
        int stop;
        int cur;
        int nxt;
        int steps;
        int freed;
        bit found;
        n = pool_blocks();
        res.status      = ST_DONE;
        res.first_block = '0;
        res.changed     = '0;
        case (kind)
            KIND_ALLOC_CONTIG: begin
                if (cnt == 0) return res;
                run = 0;
                begin_blk = 0;
                found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!occ_map[i]) begin
                        if (run == 0) begin_blk = i;
                        run++;
                        if (run == cnt) begin
                            found = 1'b1;
                            break;
                        end
                    end else begin
                        run = 0;
                    end
                end
                if (!found) begin
                    res.status = ST_NO_SPACE;
                    return res;
                end
                for (int i = begin_blk; i < begin_blk + cnt; i++) occ_map[i] = 1'b1;
                res.first_block = begin_blk[BLK_W-1:0];
                res.changed     = cnt[CNT_W-1:0];
                live_allocs.push_back('{1'b0, begin_blk, cnt});
            end
            KIND_ALLOC_CHAIN: begin
                if (cnt == 0) return res;
                nfree = 0;
                for (int i = 0; i < n; i++) if (!occ_map[i]) nfree++;
                if (nfree < cnt) begin
                    res.status = ST_NO_SPACE;
                    return res;
                end
                taken = 0;
                prev = 0;
                for (int i = 0; i < n && taken < cnt; i++) begin
                    if (occ_map[i]) continue;
                    if (taken == 0) res.first_block = i[BLK_W-1:0];
                    else link_tbl[prev] = i[LINK_W-1:0];
                    occ_map[i] = 1'b1;
                    prev = i;
                    taken++;
                end
                link_tbl[prev] = LINK_END;
                res.changed = cnt[CNT_W-1:0];
                live_allocs.push_back('{1'b1, int'(res.first_block), cnt});
            end
            KIND_FREE_RANGE: begin
                if (start >= n) begin
                    res.status = ST_BAD_START;
                    return res;
                end
                stop = (start + cnt > n) ? n : start + cnt;
                for (int i = start; i < stop; i++) occ_map[i] = 1'b0;
                res.changed = CNT_W'(stop - start);
            end
            KIND_FREE_CHAIN: begin
                if (start >= n) begin
                    res.status = ST_BAD_START;
                    return res;
                end
                // Walk ends on the marker, on a link out of the pool, or after n steps
                cur = start;
                steps = 0;
                freed = 0;
                while (cur != int'(LINK_END) && cur < n && steps < n) begin
                    nxt = int'(link_tbl[cur]);
                    if (occ_map[cur]) freed++;
                    occ_map[cur] = 1'b0;
                    link_tbl[cur] = LINK_END;
                    cur = nxt;
                    steps++;
                end
                res.changed = CNT_W'(freed);
            end
        endcase
        return res;
    endfunction

    // Sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Offer one request, wait for its transfer, record the prediction.
    // Valid stays high when the next request follows without a gap.
    task automatic send_item(t_kind kind, int cnt, int start, int gap);
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_block_count <= cnt[CNT_W-1:0];
        i_start_block <= start[BLK_W-1:0];
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_results.push_back(compute_alloc_result(kind, cnt, start));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic set_pool_size(int value);
        wait_drain();
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pool_cfg = value[CNT_W-1:0];
    endtask

    // Every operation kind on the full pool: zero length, full pool,
    // failures, clipped range, full chain walk, holes reused by a chain
    task automatic test_directed_ops();
        send_item(KIND_ALLOC_CONTIG, 0, 0, pick_gap());
        send_item(KIND_ALLOC_CHAIN, 0, 5, pick_gap());
        send_item(KIND_ALLOC_CONTIG, 128, 0, pick_gap());
        send_item(KIND_ALLOC_CONTIG, 1, 0, pick_gap());
        send_item(KIND_ALLOC_CHAIN, 1, 0, pick_gap());
        send_item(KIND_FREE_RANGE, 128, 127, pick_gap());
        send_item(KIND_FREE_RANGE, 128, 0, pick_gap());
        send_item(KIND_ALLOC_CHAIN, 128, 0, pick_gap());
        send_item(KIND_FREE_CHAIN, 0, 0, pick_gap());
        send_item(KIND_FREE_CHAIN, 0, 127, pick_gap());
        send_item(KIND_ALLOC_CONTIG, 3, 0, pick_gap());
        send_item(KIND_ALLOC_CHAIN, 4, 0, pick_gap());
        send_item(KIND_FREE_RANGE, 1, 1, pick_gap());
        send_item(KIND_ALLOC_CHAIN, 3, 0, pick_gap());
        send_item(KIND_FREE_CHAIN, 0, 3, pick_gap());
        send_item(KIND_FREE_RANGE, 0, 127, pick_gap());
        send_item(KIND_FREE_RANGE, 128, 0, pick_gap());
        wait_drain();
        live_allocs.delete();
    endtask

    // Empty pool, single block, saturated size, chain walk leaving the pool
    task automatic test_pool_extremes();
        set_pool_size(0);
        send_item(KIND_ALLOC_CONTIG, 1, 0, pick_gap());
        send_item(KIND_ALLOC_CHAIN, 1, 0, pick_gap());
        send_item(KIND_FREE_RANGE, 1, 0, pick_gap());
        send_item(KIND_FREE_CHAIN, 0, 0, pick_gap());
        set_pool_size(128);
        send_item(KIND_ALLOC_CHAIN, 20, 0, pick_gap());
        set_pool_size(16);
        send_item(KIND_FREE_CHAIN, 0, 10, pick_gap());
        send_item(KIND_FREE_RANGE, 4, 20, pick_gap());
        send_item(KIND_ALLOC_CONTIG, 16, 0, pick_gap());
        set_pool_size(1);
        send_item(KIND_FREE_RANGE, 128, 0, pick_gap());
        send_item(KIND_ALLOC_CONTIG, 1, 0, pick_gap());
        send_item(KIND_ALLOC_CONTIG, 2, 0, pick_gap());
        send_item(KIND_FREE_CHAIN, 0, 1, pick_gap());
        set_pool_size(255);
        send_item(KIND_FREE_CHAIN, 0, 16, pick_gap());
        send_item(KIND_ALLOC_CONTIG, 128, 0, pick_gap());
        send_item(KIND_FREE_RANGE, 128, 0, pick_gap());
        wait_drain();
        live_allocs.delete();
    endtask

    // Allocate/free traffic with random sizes; frees mostly target live
    // allocations, the rest is arbitrary requests
    task automatic test_random_workload(int pool_value, int items);
        int r;
        int idx;
        int cnt;
        t_alloc_rec rec;
        t_kind kind;
        set_pool_size(pool_value);
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                kind = t_kind'($urandom_range(0, 3));
                send_item(kind, $urandom_range(0, 128), $urandom_range(0, 127), pick_gap());
            end else if (live_allocs.size() != 0 && r < 50) begin
                idx = $urandom_range(0, live_allocs.size() - 1);
                rec = live_allocs[idx];
                live_allocs.delete(idx);
                if (rec.chained)
                    send_item(KIND_FREE_CHAIN, $urandom_range(0, 128), rec.first, pick_gap());
                else
                    send_item(KIND_FREE_RANGE, rec.count, rec.first, pick_gap());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80) cnt = $urandom_range(1, 8);
                else if (r < 95) cnt = $urandom_range(1, 32);
                else cnt = $urandom_range(1, 128);
                kind = $urandom_range(0, 1) ? KIND_ALLOC_CHAIN : KIND_ALLOC_CONTIG;
                send_item(kind, cnt, $urandom_range(0, 127), pick_gap());
            end
            // occasional pause until the block is empty
            if ($urandom_range(0, 39) == 0) wait_drain();
        end
        wait_drain();
    endtask

    // Output held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_cnt = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 2 && live_allocs.size() != 0)
                send_item(KIND_FREE_RANGE, live_allocs[0].count, live_allocs[0].first, 0);
            else
                send_item(KIND_ALLOC_CONTIG, $urandom_range(1, 4), 0, 0);
        end
        wait_drain();
    endtask

    // Result stall: long hold when requested, else random bursts
    initial begin
        int r;
        int burst_left;
        logic stall_level;
        burst_left  = 0;
        stall_level = 1'b0;
        i_stall     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                i_stall <= 1'b1;
                hold_cnt--;
            end else begin
                if (burst_left == 0) begin
                    r = $urandom_range(0, 19);
                    if (r < 9) begin
                        stall_level = 1'b0;
                        burst_left  = $urandom_range(1, 20);
                    end else if (r < 10) begin
                        stall_level = 1'b0;
                        burst_left  = $urandom_range(50, 150);
                    end else if (r < 18) begin
                        stall_level = 1'b1;
                        burst_left  = $urandom_range(1, 3);
                    end else begin
                        stall_level = 1'b1;
                        burst_left  = $urandom_range(20, 80);
                    end
                end
                i_stall <= stall_level;
                burst_left--;
            end
        end
    end

    // Result check against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_alloc_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: status %0d", o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_first_block !== want.first_block) begin
                    $error("first_block: expected %0d, got %0d",
                           want.first_block, o_first_block);
                    error_count++;
                end
                if (o_blocks_changed !== want.changed) begin
                    $error("blocks_changed: expected %0d, got %0d",
                           want.changed, o_blocks_changed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) || i_cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_kind        = KIND_ALLOC_CONTIG;
        i_block_count = '0;
        i_start_block = '0;
        pool_cfg      = ACT_RESET;
        for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
            occ_map[i]  = 1'b0;
            link_tbl[i] = LINK_END;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass after reset holds the request side off
        do @(posedge i_clk); while (o_stall !== 1'b0);

        test_directed_ops();
        test_pool_extremes();
        test_random_workload(128, 140);
        test_backpressure();
        test_random_workload(16, 60);
        test_random_workload(100, 60);
        test_random_workload(1, 20);
        test_random_workload(128, 80);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
